// ===== rtl/mtme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtme_pkg
// Shared types, codes and helpers for the message tag matching engine.
// ----------------------------------------------------------------------------
package mtme_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam logic [22:0] MAX_BYTES = 23'd4194304;

   // command kinds
   localparam logic [1:0] KIND_ARRIVAL = 2'd0;
   localparam logic [1:0] KIND_POST    = 2'd1;
   localparam logic [1:0] KIND_PROBE   = 2'd2;
   localparam logic [1:0] KIND_TEST    = 2'd3;

   // result status codes
   localparam logic [3:0] STS_FORWARD    = 4'd0;
   localparam logic [3:0] STS_DELIVERED  = 4'd1;
   localparam logic [3:0] STS_STASHED    = 4'd2;
   localparam logic [3:0] STS_DROPPED    = 4'd3;
   localparam logic [3:0] STS_POSTED     = 4'd4;
   localparam logic [3:0] STS_POST_SAT   = 4'd5;
   localparam logic [3:0] STS_NO_SLOT    = 4'd6;
   localparam logic [3:0] STS_PROBE_HIT  = 4'd7;
   localparam logic [3:0] STS_PROBE_MISS = 4'd8;
   localparam logic [3:0] STS_RELEASED   = 4'd9;
   localparam logic [3:0] STS_PENDING    = 4'd10;
   localparam logic [3:0] STS_INVALID    = 4'd11;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ARR_SCAN,
      ST_POST_FREE,
      ST_POST_UNEX,
      ST_POST_SHIFT,
      ST_POST_WRITE,
      ST_PROBE,
      ST_TEST_RD,
      ST_TEST_CHK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        active;
      logic        complete;
      logic        any_src;
      logic [7:0]  src;
      logic        any_tg;
      logic [15:0] tag;
      logic [7:0]  comm;
   } post_match_type;

   typedef struct packed {
      logic [22:0] cap;
      logic [22:0] rlen;
   } post_len_type;

   typedef struct packed {
      logic [7:0]  src;
      logic [15:0] tag;
      logic [7:0]  comm;
      logic [22:0] len;
   } unex_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  src;
      logic        any_src;
      logic [15:0] tag;
      logic        any_tg;
      logic [7:0]  comm;
      logic [22:0] len;
      logic        relay;
      logic [7:0]  fdest;
      logic [5:0]  rid;
   } cmd_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [5:0]  request_slot;
      logic [5:0]  unexpected_slot;
      logic [7:0]  matched_source;
      logic [15:0] matched_tag;
      logic [22:0] full_length;
      logic [22:0] copy_length;
      logic [7:0]  forward_dest;
   } result_type;

   function automatic logic [22:0] min_len(input logic [22:0] a, input logic [22:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [22:0] sat_len(input logic [22:0] a);
      return (a > MAX_BYTES) ? MAX_BYTES : a;
   endfunction

endpackage

// ===== rtl/message_tag_matching_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_tag_matching_engine
// Header matching against posted receives and an unexpected-message queue.
// ----------------------------------------------------------------------------
// steps: a forward and an out-of-range test go straight to the emit step;
// other tests read the slot, then check it; probe, arrival and post scan the
// tables through the memory read port, one entry per cycle; a post finds a
// free slot, scans the unexpected queue, compacts it on a hit, then writes
// the slot; the result waits in the emit step while the output is stalled.
// throughput: one item at a time; next item taken once the result is queued.
// reset: synchronous; a clearing pass writes each request slot inactive in
// turn, no item is accepted during it.
module message_tag_matching_engine #(
   parameter int TABLE_DEPTH = mtme_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_src_rank,
   input  logic        req_any_source,
   input  logic [15:0] req_msg_tag,
   input  logic        req_any_tag,
   input  logic [7:0]  req_comm_id,
   input  logic [22:0] req_byte_length,
   input  logic        req_relay_flag,
   input  logic [7:0]  req_final_dest,
   input  logic [5:0]  req_request_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [5:0]  rsp_request_slot,
   output logic [5:0]  rsp_unexpected_slot,
   output logic [7:0]  rsp_matched_source,
   output logic [15:0] rsp_matched_tag,
   output logic [22:0] rsp_full_length,
   output logic [22:0] rsp_copy_length,
   output logic [7:0]  rsp_forward_dest,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import mtme_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam logic [IW:0] DEPTH_W = (IW+1)'(TABLE_DEPTH);
   localparam logic [IW:0] LAST_W  = (IW+1)'(TABLE_DEPTH - 1);

   state_type   state_ff, state_in;
   logic [IW:0] scan_ff, scan_in;
   logic        chk_vld_ff, chk_vld_in;
   logic [IW:0] chk_idx_ff, chk_idx_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [IW:0] count_ff, count_in;
   cmd_type     cmd_ff, cmd_in;
   result_type  res_ff, res_in;
   result_type  out_ff, out_in;
   logic        out_vld_ff, out_vld_in;
   logic [7:0]  own_rank_ff, own_rank_in;

   logic           pm_we, pl_we, uq_we;
   logic [IW-1:0]  pm_waddr, pl_waddr, uq_waddr, rd_addr;
   post_match_type pm_wdata, pm_rdata;
   post_len_type   pl_wdata, pl_rdata;
   unex_type       uq_wdata, uq_rdata;
   logic           issue, load, stall_s;
   logic           arr_hit, unex_hit;
   logic [IW:0]    dec_idx;

   // state memories
   mtme_ram #(.WIDTH($bits(post_match_type)), .DEPTH(TABLE_DEPTH)) u_post_match (
      .clock(clock), .wr_en(pm_we), .wr_addr(pm_waddr), .wr_data(pm_wdata),
      .rd_addr(rd_addr), .rd_data(pm_rdata)
   );
   mtme_ram #(.WIDTH($bits(post_len_type)), .DEPTH(TABLE_DEPTH)) u_post_len (
      .clock(clock), .wr_en(pl_we), .wr_addr(pl_waddr), .wr_data(pl_wdata),
      .rd_addr(rd_addr), .rd_data(pl_rdata)
   );
   mtme_ram #(.WIDTH($bits(unex_type)), .DEPTH(TABLE_DEPTH)) u_unex (
      .clock(clock), .wr_en(uq_we), .wr_addr(uq_waddr), .wr_data(uq_wdata),
      .rd_addr(rd_addr), .rd_data(uq_rdata)
   );

   assign rd_addr = scan_ff[IW-1:0];
   assign dec_idx = chk_idx_ff - 1'b1;

   // match terms against the word read last cycle
   assign arr_hit = pm_rdata.active && !pm_rdata.complete && (pm_rdata.comm == cmd_ff.comm)
                 && (pm_rdata.any_src || (pm_rdata.src == cmd_ff.src))
                 && (pm_rdata.any_tg || (pm_rdata.tag == cmd_ff.tag));
   assign unex_hit = (uq_rdata.comm == cmd_ff.comm)
                  && (cmd_ff.any_src || (uq_rdata.src == cmd_ff.src))
                  && (cmd_ff.any_tg || (uq_rdata.tag == cmd_ff.tag));

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         scan_ff     <= '0;
         chk_vld_ff  <= 1'b0;
         count_ff    <= '0;
         out_vld_ff  <= 1'b0;
         own_rank_ff <= 8'd0;
      end else begin
         state_ff    <= state_in;
         scan_ff     <= scan_in;
         chk_vld_ff  <= chk_vld_in;
         count_ff    <= count_in;
         out_vld_ff  <= out_vld_in;
         own_rank_ff <= own_rank_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      slot_ff    <= slot_in;
      cmd_ff     <= cmd_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = scan_ff;
      slot_in    = slot_ff;
      count_in   = count_ff;
      cmd_in     = cmd_ff;
      res_in     = res_ff;
      pm_we      = 1'b0;
      pm_waddr   = chk_idx_ff[IW-1:0];
      pm_wdata   = '0;
      pl_we      = 1'b0;
      pl_waddr   = chk_idx_ff[IW-1:0];
      pl_wdata   = '0;
      uq_we      = 1'b0;
      uq_waddr   = count_ff[IW-1:0];
      uq_wdata   = '0;
      issue      = 1'b0;
      load       = 1'b0;
      stall_s    = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            pm_we    = 1'b1;
            pm_waddr = scan_ff[IW-1:0];
            if (scan_ff == LAST_W) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            stall_s = 1'b0;
            if (req_valid) begin
               cmd_in.kind    = req_kind;
               cmd_in.src     = req_src_rank;
               cmd_in.any_src = req_any_source;
               cmd_in.tag     = req_msg_tag;
               cmd_in.any_tg  = req_any_tag;
               cmd_in.comm    = req_comm_id;
               cmd_in.len     = sat_len(req_byte_length);
               cmd_in.relay   = req_relay_flag;
               cmd_in.fdest   = req_final_dest;
               cmd_in.rid     = req_request_id;
               res_in  = '0;
               scan_in = '0;
               unique case (req_kind)
                  KIND_ARRIVAL: begin
                     if (req_relay_flag && (req_final_dest != own_rank_ff)) begin
                        res_in.status       = STS_FORWARD;
                        res_in.forward_dest = req_final_dest;
                        state_in            = ST_EMIT;
                     end else begin
                        state_in = ST_ARR_SCAN;
                     end
                  end
                  KIND_POST:  state_in = ST_POST_FREE;
                  KIND_PROBE: state_in = ST_PROBE;
                  KIND_TEST: begin
                     if (32'(req_request_id) >= TABLE_DEPTH) begin
                        res_in.status = STS_INVALID;
                        state_in      = ST_EMIT;
                     end else begin
                        scan_in  = (IW+1)'(req_request_id);
                        state_in = ST_TEST_RD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         // arrival: first pending posted receive that matches, else stash or drop it
         ST_ARR_SCAN: begin
            issue      = scan_ff < DEPTH_W;
            chk_vld_in = issue;
            if (issue) scan_in = scan_ff + 1'b1;
            if (chk_vld_ff && arr_hit) begin
               chk_vld_in        = 1'b0;
               pm_we             = 1'b1;
               pm_wdata          = pm_rdata;
               pm_wdata.complete = 1'b1;
               pm_wdata.src      = cmd_ff.src;
               pm_wdata.tag      = cmd_ff.tag;
               pl_we             = 1'b1;
               pl_wdata.cap      = pl_rdata.cap;
               pl_wdata.rlen     = cmd_ff.len;
               res_in.status         = STS_DELIVERED;
               res_in.request_slot   = 6'(chk_idx_ff);
               res_in.matched_source = cmd_ff.src;
               res_in.matched_tag    = cmd_ff.tag;
               res_in.full_length    = cmd_ff.len;
               res_in.copy_length    = min_len(cmd_ff.len, pl_rdata.cap);
               state_in              = ST_EMIT;
            end else if (!issue && !chk_vld_ff) begin
               if (count_ff < DEPTH_W) begin
                  uq_we                  = 1'b1;
                  uq_wdata.src           = cmd_ff.src;
                  uq_wdata.tag           = cmd_ff.tag;
                  uq_wdata.comm          = cmd_ff.comm;
                  uq_wdata.len           = cmd_ff.len;
                  res_in.status          = STS_STASHED;
                  res_in.unexpected_slot = 6'(count_ff);
                  count_in               = count_ff + 1'b1;
               end else begin
                  res_in.status = STS_DROPPED;
               end
               state_in = ST_EMIT;
            end
         end
         // post: first free request slot
         ST_POST_FREE: begin
            issue      = scan_ff < DEPTH_W;
            chk_vld_in = issue;
            if (issue) scan_in = scan_ff + 1'b1;
            if (chk_vld_ff && !pm_rdata.active) begin
               chk_vld_in          = 1'b0;
               slot_in             = chk_idx_ff[IW-1:0];
               res_in.request_slot = 6'(chk_idx_ff);
               scan_in             = '0;
               state_in            = ST_POST_UNEX;
            end else if (!issue && !chk_vld_ff) begin
               res_in.status = STS_NO_SLOT;
               state_in      = ST_EMIT;
            end
         end
         // post: oldest matching unexpected entry
         ST_POST_UNEX: begin
            issue      = scan_ff < count_ff;
            chk_vld_in = issue;
            if (issue) scan_in = scan_ff + 1'b1;
            if (chk_vld_ff && unex_hit) begin
               chk_vld_in             = 1'b0;
               res_in.status          = STS_POST_SAT;
               res_in.unexpected_slot = 6'(chk_idx_ff);
               res_in.matched_source  = uq_rdata.src;
               res_in.matched_tag     = uq_rdata.tag;
               res_in.full_length     = uq_rdata.len;
               res_in.copy_length     = min_len(uq_rdata.len, cmd_ff.len);
               scan_in                = chk_idx_ff + 1'b1;
               state_in               = ST_POST_SHIFT;
            end else if (!issue && !chk_vld_ff) begin
               res_in.status = STS_POSTED;
               state_in      = ST_POST_WRITE;
            end
         end
         // compact the queue over the removed entry
         ST_POST_SHIFT: begin
            issue      = scan_ff < count_ff;
            chk_vld_in = issue;
            if (issue) scan_in = scan_ff + 1'b1;
            if (chk_vld_ff) begin
               uq_we    = 1'b1;
               uq_waddr = dec_idx[IW-1:0];
               uq_wdata = uq_rdata;
            end
            if (!issue && !chk_vld_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_POST_WRITE;
            end
         end
         ST_POST_WRITE: begin
            pm_we            = 1'b1;
            pm_waddr         = slot_ff;
            pm_wdata.active  = 1'b1;
            pm_wdata.any_src = cmd_ff.any_src;
            pm_wdata.any_tg  = cmd_ff.any_tg;
            pm_wdata.comm    = cmd_ff.comm;
            pl_we            = 1'b1;
            pl_waddr         = slot_ff;
            pl_wdata.cap     = cmd_ff.len;
            if (res_ff.status == STS_POST_SAT) begin
               pm_wdata.complete = 1'b1;
               pm_wdata.src      = res_ff.matched_source;
               pm_wdata.tag      = res_ff.matched_tag;
               pl_wdata.rlen     = res_ff.full_length;
            end else begin
               pm_wdata.complete = 1'b0;
               pm_wdata.src      = cmd_ff.src;
               pm_wdata.tag      = cmd_ff.tag;
               pl_wdata.rlen     = 23'd0;
            end
            state_in = ST_EMIT;
         end
         // probe: oldest matching unexpected entry, left in place
         ST_PROBE: begin
            issue      = scan_ff < count_ff;
            chk_vld_in = issue;
            if (issue) scan_in = scan_ff + 1'b1;
            if (chk_vld_ff && unex_hit) begin
               chk_vld_in             = 1'b0;
               res_in.status          = STS_PROBE_HIT;
               res_in.unexpected_slot = 6'(chk_idx_ff);
               res_in.matched_source  = uq_rdata.src;
               res_in.matched_tag     = uq_rdata.tag;
               res_in.full_length     = uq_rdata.len;
               state_in               = ST_EMIT;
            end else if (!issue && !chk_vld_ff) begin
               res_in.status = STS_PROBE_MISS;
               state_in      = ST_EMIT;
            end
         end
         ST_TEST_RD: begin
            state_in = ST_TEST_CHK;
         end
         // test: report and free a completed request
         ST_TEST_CHK: begin
            if (!pm_rdata.active) begin
               res_in.status = STS_INVALID;
            end else if (!pm_rdata.complete) begin
               res_in.status       = STS_PENDING;
               res_in.request_slot = cmd_ff.rid;
            end else begin
               res_in.status         = STS_RELEASED;
               res_in.request_slot   = cmd_ff.rid;
               res_in.matched_source = pm_rdata.src;
               res_in.matched_tag    = pm_rdata.tag;
               res_in.full_length    = pl_rdata.rlen;
               res_in.copy_length    = min_len(pl_rdata.rlen, pl_rdata.cap);
               pm_we                 = 1'b1;
               pm_waddr              = scan_ff[IW-1:0];
               pm_wdata              = pm_rdata;
               pm_wdata.active       = 1'b0;
               pm_wdata.complete     = 1'b0;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_vld_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      out_in     = load ? res_ff : out_ff;
      out_vld_in = load ? 1'b1 : (out_vld_ff && rsp_stall);
   end

   // configuration register
   always_comb begin
      own_rank_in = (csr_valid && csr_ready) ? csr_data : own_rank_ff;
   end

   assign csr_ready           = 1'b1;
   assign req_stall           = stall_s;
   assign rsp_valid           = out_vld_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_request_slot    = out_ff.request_slot;
   assign rsp_unexpected_slot = out_ff.unexpected_slot;
   assign rsp_matched_source  = out_ff.matched_source;
   assign rsp_matched_tag     = out_ff.matched_tag;
   assign rsp_full_length     = out_ff.full_length;
   assign rsp_copy_length     = out_ff.copy_length;
   assign rsp_forward_dest    = out_ff.forward_dest;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_W)
      else $error("unexpected queue count above depth");

   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("item accepted during clearing pass");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EMIT))
      else $error("result shown without emit step");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STS_INVALID))
      else $error("result status out of range");

endmodule

// ===== rtl/mtme_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtme_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mtme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_message_tag_matching_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_tag_matching_engine
// Drives arrival, post, probe and test commands into the matching engine,
// predicts every result word with a behavioral copy of the posted-receive
// table and the unexpected queue, and compares field by field.
// ----------------------------------------------------------------------------
module tb_message_tag_matching_engine;
   import mtme_pkg::*;

   localparam int DEPTH    = DEFAULT_TABLE_DEPTH;
   localparam int WDOG_MAX = 20000;
   localparam int N_RANDOM = 816;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = '0;
   logic [7:0]  req_src_rank = '0;
   logic        req_any_source = 1'b0;
   logic [15:0] req_msg_tag = '0;
   logic        req_any_tag = 1'b0;
   logic [7:0]  req_comm_id = '0;
   logic [22:0] req_byte_length = '0;
   logic        req_relay_flag = 1'b0;
   logic [7:0]  req_final_dest = '0;
   logic [5:0]  req_request_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [5:0]  rsp_request_slot;
   logic [5:0]  rsp_unexpected_slot;
   logic [7:0]  rsp_matched_source;
   logic [15:0] rsp_matched_tag;
   logic [22:0] rsp_full_length;
   logic [22:0] rsp_copy_length;
   logic [7:0]  rsp_forward_dest;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   message_tag_matching_engine dut (.*);

   always #2 clock = ~clock;

   // shadow state of the engine
   post_match_type slot_match [DEPTH];
   post_len_type   slot_len   [DEPTH];
   unex_type       unex_q     [$];
   logic [7:0]     rank_shadow;

   result_type result_q [$];
   int  errors = 0;
   int  wdog = 0;
   bit  quiet = 1'b0;

   typedef struct {
      cmd_type    cmd;
      bit         has_exp;
      result_type exp;
   } dir_row_type;

   function automatic bit unex_hit(unex_type h, cmd_type c);
      return h.comm == c.comm && (c.any_src || h.src == c.src) &&
             (c.any_tg || h.tag == c.tag);
   endfunction

   function automatic logic [22:0] lmin(logic [22:0] a, logic [22:0] b);
      return a < b ? a : b;
   endfunction

   // compute the result word of one command and update the shadow state
   function automatic result_type match_engine_step(cmd_type c);
      result_type r;
      logic [22:0] len;
      int slot;
      bit done;
      r = '0;
      len = c.len > MAX_BYTES ? MAX_BYTES : c.len;
      case (c.kind)
         KIND_ARRIVAL: begin
            if (c.relay && c.fdest != rank_shadow) begin
               r.status = STS_FORWARD;
               r.forward_dest = c.fdest;
            end else begin
               done = 1'b0;
               for (int i = 0; i < DEPTH && !done; i++) begin
                  if (slot_match[i].active && !slot_match[i].complete &&
                      slot_match[i].comm == c.comm &&
                      (slot_match[i].any_src || slot_match[i].src == c.src) &&
                      (slot_match[i].any_tg || slot_match[i].tag == c.tag)) begin
                     slot_match[i].complete = 1'b1;
                     slot_match[i].src = c.src;
                     slot_match[i].tag = c.tag;
                     slot_len[i].rlen = len;
                     r.status = STS_DELIVERED;
                     r.request_slot = 6'(i);
                     r.matched_source = c.src;
                     r.matched_tag = c.tag;
                     r.full_length = len;
                     r.copy_length = lmin(len, slot_len[i].cap);
                     done = 1'b1;
                  end
               end
               if (!done) begin
                  if (unex_q.size() < DEPTH) begin
                     r.status = STS_STASHED;
                     r.unexpected_slot = 6'(unex_q.size());
                     unex_q.push_back('{src: c.src, tag: c.tag, comm: c.comm, len: len});
                  end else r.status = STS_DROPPED;
               end
            end
         end
         KIND_POST: begin
            slot = -1;
            for (int i = 0; i < DEPTH && slot < 0; i++)
               if (!slot_match[i].active) slot = i;
            if (slot < 0) r.status = STS_NO_SLOT;
            else begin
               slot_match[slot] = '{active: 1'b1, complete: 1'b0, any_src: c.any_src,
                  src: c.src, any_tg: c.any_tg, tag: c.tag, comm: c.comm};
               slot_len[slot] = '{cap: len, rlen: '0};
               r.status = STS_POSTED;
               r.request_slot = 6'(slot);
               done = 1'b0;
               for (int i = 0; i < unex_q.size() && !done; i++) begin
                  if (unex_hit(unex_q[i], c)) begin
                     slot_match[slot].complete = 1'b1;
                     slot_match[slot].src = unex_q[i].src;
                     slot_match[slot].tag = unex_q[i].tag;
                     slot_len[slot].rlen = unex_q[i].len;
                     r.status = STS_POST_SAT;
                     r.unexpected_slot = 6'(i);
                     r.matched_source = unex_q[i].src;
                     r.matched_tag = unex_q[i].tag;
                     r.full_length = unex_q[i].len;
                     r.copy_length = lmin(unex_q[i].len, len);
                     unex_q.delete(i);
                     done = 1'b1;
                  end
               end
            end
         end
         KIND_PROBE: begin
            r.status = STS_PROBE_MISS;
            done = 1'b0;
            for (int i = 0; i < unex_q.size() && !done; i++) begin
               if (unex_hit(unex_q[i], c)) begin
                  r.status = STS_PROBE_HIT;
                  r.unexpected_slot = 6'(i);
                  r.matched_source = unex_q[i].src;
                  r.matched_tag = unex_q[i].tag;
                  r.full_length = unex_q[i].len;
                  done = 1'b1;
               end
            end
         end
         default: begin
            if (!slot_match[c.rid].active) r.status = STS_INVALID;
            else if (!slot_match[c.rid].complete) begin
               r.status = STS_PENDING;
               r.request_slot = c.rid;
            end else begin
               r.status = STS_RELEASED;
               r.request_slot = c.rid;
               r.matched_source = slot_match[c.rid].src;
               r.matched_tag = slot_match[c.rid].tag;
               r.full_length = slot_len[c.rid].rlen;
               r.copy_length = lmin(slot_len[c.rid].rlen, slot_len[c.rid].cap);
               slot_match[c.rid].active = 1'b0;
               slot_match[c.rid].complete = 1'b0;
            end
         end
      endcase
      return r;
   endfunction

   // result checking and watchdog
   always @(posedge clock) begin
      result_type got, want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) wdog <= 0;
         else wdog <= wdog + 1;
         if (wdog >= WDOG_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_request_slot, rsp_unexpected_slot, rsp_matched_source,
                 rsp_matched_tag, rsp_full_length, rsp_copy_length, rsp_forward_dest};
         if (result_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result word: expected none actual %h", $realtime, got);
         end else begin
            want = result_q.pop_front();
            if (got.status != want.status || got.request_slot != want.request_slot ||
                got.unexpected_slot != want.unexpected_slot ||
                got.matched_source != want.matched_source ||
                got.matched_tag != want.matched_tag ||
                got.full_length != want.full_length ||
                got.copy_length != want.copy_length ||
                got.forward_dest != want.forward_dest) begin
               errors++;
               $display("%0t mismatch: expected %h actual %h", $realtime, want, got);
            end
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      int n;
      @(negedge clock);
      while (1) begin
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 30);
         end else begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 19);
         end
         repeat (n) @(negedge clock);
      end
   end

   // valid stays up after an accept until the next word or an idle gap
   task automatic send_cmd(cmd_type c, bit has_exp, result_type exp);
      result_type p;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      p = match_engine_step(c);
      if (has_exp && p != exp) begin
         errors++;
         $display("%0t table row disagrees: expected %h predicted %h", $realtime, exp, p);
      end
      result_q.push_back(p);
      req_valid <= 1'b1;
      {req_kind, req_src_rank, req_any_source, req_msg_tag, req_any_tag, req_comm_id,
       req_byte_length, req_relay_flag, req_final_dest, req_request_id} <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (result_q.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (3 * DEPTH + 20) @(negedge clock);
   endtask

   task automatic write_rank(logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      rank_shadow = v;
   endtask

   // random command with content biased toward matches
   function automatic cmd_type rand_cmd(int pool);
      cmd_type c;
      c = '0;
      c.kind = 2'($urandom_range(0, 3));
      c.src = pool ? 8'($urandom_range(0, 3)) : 8'($urandom);
      c.any_src = ($urandom_range(0, 3) == 0);
      c.tag = pool ? 16'($urandom_range(0, 3)) : 16'($urandom);
      c.any_tg = ($urandom_range(0, 3) == 0);
      c.comm = pool ? 8'($urandom_range(0, 1)) : 8'($urandom);
      case ($urandom_range(0, 5))
         0: c.len = 23'(23'h7FFFFF - $urandom_range(0, 3));
         1: c.len = 23'(MAX_BYTES - 1 + $urandom_range(0, 2));
         default: c.len = 23'($urandom);
      endcase
      c.relay = ($urandom_range(0, 4) == 0);
      c.fdest = ($urandom_range(0, 1)) ? rank_shadow : 8'($urandom);
      c.rid = ($urandom_range(0, 2) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
      return c;
   endfunction

   initial begin
      dir_row_type rows [$];
      cmd_type     c;
      for (int i = 0; i < DEPTH; i++) begin
         slot_match[i] = '0;
         slot_len[i] = '0;
      end
      rank_shadow = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: expected words given where obvious
      c = '0; c.kind = KIND_TEST; c.rid = 6'd63;
      rows.push_back('{c, 1, '{STS_INVALID, 0, 0, 0, 0, 0, 0, 0}});
      c = '0; c.kind = KIND_PROBE; c.any_src = 1'b1; c.any_tg = 1'b1;
      rows.push_back('{c, 1, '{STS_PROBE_MISS, 0, 0, 0, 0, 0, 0, 0}});
      c = '0; c.kind = KIND_ARRIVAL; c.relay = 1'b1; c.fdest = 8'hFF;
      rows.push_back('{c, 1, '{STS_FORWARD, 0, 0, 0, 0, 0, 0, 8'hFF}});
      c = '0; c.kind = KIND_ARRIVAL; c.src = 8'hFF; c.tag = 16'hFFFF; c.comm = 8'hFF;
      c.len = 23'h7FFFFF;
      rows.push_back('{c, 1, '{STS_STASHED, 0, 0, 0, 0, 0, 0, 0}});
      c = '0; c.kind = KIND_PROBE; c.src = 8'hFF; c.tag = 16'hFFFF; c.comm = 8'hFF;
      rows.push_back('{c, 1, '{STS_PROBE_HIT, 0, 0, 8'hFF, 16'hFFFF, MAX_BYTES, 0, 0}});
      c = '0; c.kind = KIND_POST; c.src = 8'h12; c.tag = 16'h34; c.len = 23'd100;
      rows.push_back('{c, 1, '{STS_POSTED, 0, 0, 0, 0, 0, 0, 0}});
      c = '0; c.kind = KIND_TEST; c.rid = 6'd0;
      rows.push_back('{c, 1, '{STS_PENDING, 0, 0, 0, 0, 0, 0, 0}});
      c = '0; c.kind = KIND_ARRIVAL; c.src = 8'h12; c.tag = 16'h34; c.len = 23'd500;
      c.relay = 1'b1;
      rows.push_back('{c, 0, '0});
      c = '0; c.kind = KIND_TEST; c.rid = 6'd0;
      rows.push_back('{c, 0, '0});
      c = '0; c.kind = KIND_POST; c.any_src = 1'b1; c.any_tg = 1'b1; c.comm = 8'hFF;
      c.len = 23'd3;
      rows.push_back('{c, 0, '0});
      c = '0; c.kind = KIND_TEST; c.rid = 6'd0;
      rows.push_back('{c, 0, '0});
      c = '0; c.kind = KIND_TEST; c.rid = 6'd0;
      rows.push_back('{c, 1, '{STS_INVALID, 0, 0, 0, 0, 0, 0, 0}});
      foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].has_exp, rows[i].exp);

      // fill the posted table to hit no slot, then overflow the queue
      drain();
      write_rank(8'hFF);
      for (int i = 0; i < DEPTH + 1; i++) begin
         c = '0; c.kind = KIND_POST; c.src = 8'h55; c.tag = 16'(i); c.comm = 8'hAA;
         send_cmd(c, 0, '0);
      end
      for (int i = 0; i < DEPTH + 2; i++) begin
         c = '0; c.kind = KIND_ARRIVAL; c.src = 8'(i); c.tag = 16'hBEEF; c.comm = 8'h01;
         c.len = 23'(i);
         send_cmd(c, 0, '0);
      end
      for (int i = 0; i < DEPTH; i++) begin
         c = '0; c.kind = KIND_TEST; c.rid = 6'(i);
         send_cmd(c, 0, '0);
      end

      // complete every posted slot, then release them all
      for (int i = 0; i < DEPTH; i++) begin
         c = '0; c.kind = KIND_ARRIVAL; c.src = 8'h55; c.tag = 16'(i); c.comm = 8'hAA;
         c.len = 23'(i * 16);
         send_cmd(c, 0, '0);
      end
      for (int i = 0; i < DEPTH; i++) begin
         c = '0; c.kind = KIND_TEST; c.rid = 6'(i);
         send_cmd(c, 0, '0);
      end

      // random phases under several rank settings
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         write_rank(ph == 0 ? 8'h00 : ph == 1 ? 8'h80 : 8'($urandom));
         if (ph == 3) quiet = 1'b1;
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            c = rand_cmd($urandom_range(0, 9) != 0);
            send_cmd(c, 0, '0);
         end
      end

      drain();
      if (errors == 0 && result_q.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
